### hdl/scpv_pkg.sv
package scpv_pkg;

    // Packet framing constants.
    localparam logic [31:0] SYNC_PATTERN     = 32'h55AA55AA;
    localparam logic [31:0] CRC_INIT         = 32'hFFFFFFFF;
    localparam logic [15:0] MAX_PACKET_BYTES = 16'hFFFF;
    localparam logic [15:0] MIN_PACKET_BYTES = 16'd12;

    // Byte positions of the header fields.
    localparam logic [15:0] POS_LEN_LO  = 16'd4;
    localparam logic [15:0] POS_LEN_HI  = 16'd5;
    localparam logic [15:0] POS_TYPE    = 16'd6;
    localparam logic [15:0] POS_COUNTER = 16'd7;

    // Status codes, in priority order.
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_BAD_SYNC    = 3'd1;
    localparam logic [2:0] STATUS_BAD_LENGTH  = 3'd2;
    localparam logic [2:0] STATUS_BAD_TYPE    = 3'd3;
    localparam logic [2:0] STATUS_BAD_CRC     = 3'd4;
    localparam logic [2:0] STATUS_BAD_COUNTER = 3'd5;

    // Configuration register indexes.
    localparam logic [7:0] CFG_WANTED_TYPE  = 8'd0;
    localparam logic [7:0] CFG_SKIP_COUNTER = 8'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } scpv_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] sequence_number;
    } scpv_out_t;

    // Nibble table for polynomial 0x04C11DB7.
    function automatic logic [31:0] nibble_entry(input logic [3:0] idx);
        logic [31:0] e;
        unique case (idx)
            4'h0: e = 32'h00000000;
            4'h1: e = 32'h04C11DB7;
            4'h2: e = 32'h09823B6E;
            4'h3: e = 32'h0D4326D9;
            4'h4: e = 32'h130476DC;
            4'h5: e = 32'h17C56B6B;
            4'h6: e = 32'h1A864DB2;
            4'h7: e = 32'h1E475005;
            4'h8: e = 32'h2608EDB8;
            4'h9: e = 32'h22C9F00F;
            4'hA: e = 32'h2F8AD6D6;
            4'hB: e = 32'h2B4BCB61;
            4'hC: e = 32'h350C9B64;
            4'hD: e = 32'h31CD86D3;
            4'hE: e = 32'h3C8EA00A;
            4'hF: e = 32'h384FBDBD;
        endcase
        return e;
    endfunction

    // One byte of the CRC: the byte goes into the low bits, then eight
    // nibble steps shift the register left through the table.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'h000000, b};
        for (int k = 0; k < 8; k++) begin
            c = {c[27:0], 4'h0} ^ nibble_entry(c[31:28]);
        end
        return c;
    endfunction

endpackage

### hdl/sync_crc_packet_validator.sv
// Channel   | Ports                                   | Moves
// ----------+-----------------------------------------+-------------------------------
// input     | s_valid, s_ready, s_data (scpv_in_t)    | one packet byte, last flag
// result    | m_valid, m_ready, m_data (scpv_out_t)   | status and sequence byte
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// One byte is taken per cycle while s_ready is high; the CRC step, field capture and checks all happen
// in the accept cycle and the result appears in the output register in the next cycle.
// Reset is synchronous on aresetn low and clears config, packet state and m_valid, but not m_data.
// A waiting result stalls only a last byte; other bytes keep flowing past it.
// Configuration writes are always taken (cfg_ready is held high).
module sync_crc_packet_validator
    import scpv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  scpv_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output scpv_out_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]  wanted_type_reg;
    logic        skip_counter_reg;
    logic [15:0] byte_count_reg,   byte_count_next;
    logic [31:0] crc_reg,          crc_next;
    logic [31:0] tail_reg,         tail_next;
    logic [31:0] sync_word_reg,    sync_word_next;
    logic [15:0] length_reg,       length_next;
    logic [7:0]  type_reg,         type_next;
    logic [7:0]  counter_reg,      counter_next;
    logic [7:0]  prev_counter_reg, prev_counter_next;
    logic        too_long_reg,     too_long_next;
    logic        m_valid_reg,      m_valid_next;
    scpv_out_t   m_data_reg,       m_data_next;

    // Values after this byte is taken in, before the end-of-packet clear.
    logic [15:0] upd_count;
    logic [31:0] upd_crc;
    logic [31:0] upd_tail;
    logic [31:0] upd_sync;
    logic [15:0] upd_length;
    logic [7:0]  upd_type;
    logic [7:0]  upd_counter;
    logic        upd_too_long;
    logic [2:0]  status;
    logic        accept;
    logic        accept_last;

    // A byte that ends a packet needs room in the output register.
    assign s_ready     = !m_valid_reg || m_ready || !s_data.last_byte;
    assign accept      = s_valid && s_ready;
    assign accept_last = accept && s_data.last_byte;
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    // Field capture, tail window and CRC step for one byte.
    always_comb begin
        upd_count    = byte_count_reg;
        upd_crc      = crc_reg;
        upd_tail     = tail_reg;
        upd_sync     = sync_word_reg;
        upd_length   = length_reg;
        upd_type     = type_reg;
        upd_counter  = counter_reg;
        upd_too_long = too_long_reg;
        if (!too_long_reg) begin
            if (byte_count_reg < POS_LEN_LO) begin
                upd_sync[byte_count_reg[1:0]*8 +: 8] = s_data.data_byte;
            end
            if (byte_count_reg == POS_LEN_LO) begin
                upd_length[7:0] = s_data.data_byte;
            end
            if (byte_count_reg == POS_LEN_HI) begin
                upd_length[15:8] = s_data.data_byte;
            end
            if (byte_count_reg == POS_TYPE) begin
                upd_type = s_data.data_byte;
            end
            if (byte_count_reg == POS_COUNTER) begin
                upd_counter = s_data.data_byte;
            end
            // The oldest tail byte enters the CRC as the new byte pushes in.
            if (byte_count_reg >= POS_LEN_LO) begin
                upd_crc = crc_byte(crc_reg, tail_reg[7:0]);
            end
            upd_tail = {s_data.data_byte, tail_reg[31:8]};
            if (byte_count_reg >= MAX_PACKET_BYTES) begin
                upd_too_long = 1'b1;
            end else begin
                upd_count = byte_count_reg + 16'd1;
            end
        end
    end

    // Packet checks in priority order.
    always_comb begin
        priority if (upd_sync != SYNC_PATTERN) begin
            status = STATUS_BAD_SYNC;
        end else if (upd_too_long || upd_count < MIN_PACKET_BYTES ||
                     upd_length != upd_count) begin
            status = STATUS_BAD_LENGTH;
        end else if (upd_type != wanted_type_reg) begin
            status = STATUS_BAD_TYPE;
        end else if (upd_crc != upd_tail) begin
            status = STATUS_BAD_CRC;
        end else if (!skip_counter_reg && (prev_counter_reg + 8'd1) != upd_counter) begin
            status = STATUS_BAD_COUNTER;
        end else begin
            status = STATUS_OK;
        end
    end

    // Next state: take the updated values, or clear them at the end of a packet.
    always_comb begin
        byte_count_next   = byte_count_reg;
        crc_next          = crc_reg;
        tail_next         = tail_reg;
        sync_word_next    = sync_word_reg;
        length_next       = length_reg;
        type_next         = type_reg;
        counter_next      = counter_reg;
        too_long_next     = too_long_reg;
        prev_counter_next = prev_counter_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept_last) begin
            byte_count_next = '0;
            crc_next        = CRC_INIT;
            tail_next       = '0;
            sync_word_next  = '0;
            length_next     = '0;
            type_next       = '0;
            counter_next    = '0;
            too_long_next   = 1'b0;
            if (status == STATUS_OK || status == STATUS_BAD_COUNTER) begin
                prev_counter_next = upd_counter;
            end
            m_valid_next                = 1'b1;
            m_data_next.status          = status;
            m_data_next.sequence_number = upd_counter;
        end else if (accept) begin
            byte_count_next = upd_count;
            crc_next        = upd_crc;
            tail_next       = upd_tail;
            sync_word_next  = upd_sync;
            length_next     = upd_length;
            type_next       = upd_type;
            counter_next    = upd_counter;
            too_long_next   = upd_too_long;
        end
    end

    // Control and packet state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_type_reg  <= '0;
            skip_counter_reg <= 1'b0;
            byte_count_reg   <= '0;
            crc_reg          <= CRC_INIT;
            tail_reg         <= '0;
            sync_word_reg    <= '0;
            length_reg       <= '0;
            type_reg         <= '0;
            counter_reg      <= '0;
            prev_counter_reg <= '0;
            too_long_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WANTED_TYPE) begin
                    wanted_type_reg <= cfg_data;
                end
                if (cfg_index == CFG_SKIP_COUNTER) begin
                    skip_counter_reg <= cfg_data[0];
                end
            end
            byte_count_reg   <= byte_count_next;
            crc_reg          <= crc_next;
            tail_reg         <= tail_next;
            sync_word_reg    <= sync_word_next;
            length_reg       <= length_next;
            type_reg         <= type_next;
            counter_reg      <= counter_next;
            prev_counter_reg <= prev_counter_next;
            too_long_reg     <= too_long_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

### hdl/scpv_checker.sv
module scpv_checker
    import scpv_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input scpv_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input scpv_out_t m_data
);

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A last byte is never taken while an unread result would be overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !(s_valid && s_ready && s_data.last_byte))
        else $error("last byte accepted over a waiting result");

    // Every accepted last byte produces a result in the next cycle.
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_byte |=> m_valid)
        else $error("no result after last byte");

    // A new result only follows an accepted last byte.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.last_byte && !(m_valid && !m_ready) |=> !m_valid)
        else $error("result without a last byte");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= STATUS_BAD_COUNTER)
        else $error("undefined status code");

endmodule

bind sync_crc_packet_validator scpv_checker u_scpv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import scpv_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          RANDOM_ITEMS   = 1200;
    localparam int          RANDOM_PHASES  = 5;
    localparam logic [31:0] CRC_POLY       = 32'h04C11DB7;

    // Tracks the framing state of the packet in flight and keeps the statuses
    // that accepted last bytes have yet to produce.
    class frame_status_scoreboard;
        logic [7:0]  wanted_type;
        logic        skip_counter;
        logic [15:0] byte_cnt;
        logic [31:0] crc_acc;
        logic [31:0] tail_word;
        logic [31:0] sync_acc;
        logic [15:0] len_acc;
        logic [7:0]  type_acc;
        logic [7:0]  count_acc;
        logic [7:0]  prev_count;
        bit          overlong;
        scpv_out_t   expected_status_q[$];
        int          mismatches;

        function new();
            wanted_type  = 8'h00;
            skip_counter = 1'b0;
            prev_count   = 8'h00;
            mismatches   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_cnt  = 16'h0000;
            crc_acc   = CRC_INIT;
            tail_word = 32'h0;
            sync_acc  = 32'h0;
            len_acc   = 16'h0000;
            type_acc  = 8'h00;
            count_acc = 8'h00;
            overlong  = 1'b0;
        endfunction

        // Bit-serial CRC, MSB first: 32 single-bit shifts per byte.
        static function logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b);
            logic [31:0] c;
            c = crc ^ {24'h000000, b};
            for (int k = 0; k < 32; k++) begin
                c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            return c;
        endfunction

        function void write_reg(logic [7:0] idx, logic [7:0] val);
            if (idx == CFG_WANTED_TYPE) begin
                wanted_type = val;
            end else if (idx == CFG_SKIP_COUNTER) begin
                skip_counter = val[0];
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: mismatch: %s", $realtime, msg);
            end
        endfunction

        // Predicts the effect of one accepted input transaction.
        function void note_byte(scpv_in_t item);
            scpv_out_t  res;
            logic [7:0] next_count;
            if (!overlong) begin
                if (byte_cnt < 16'd4) begin
                    sync_acc = sync_acc | ({24'h000000, item.data_byte} << (8 * byte_cnt[1:0]));
                end else if (byte_cnt == POS_LEN_LO) begin
                    len_acc[7:0] = item.data_byte;
                end else if (byte_cnt == POS_LEN_HI) begin
                    len_acc[15:8] = item.data_byte;
                end else if (byte_cnt == POS_TYPE) begin
                    type_acc = item.data_byte;
                end else if (byte_cnt == POS_COUNTER) begin
                    count_acc = item.data_byte;
                end
                // A byte enters the CRC as it drops out of the four-byte tail.
                if (byte_cnt >= 16'd4) begin
                    crc_acc = crc_update(crc_acc, tail_word[7:0]);
                end
                tail_word = {item.data_byte, tail_word[31:8]};
                if (byte_cnt == MAX_PACKET_BYTES) begin
                    overlong = 1'b1;
                end else begin
                    byte_cnt = byte_cnt + 16'd1;
                end
            end
            if (item.last_byte) begin
                next_count = prev_count + 8'd1;
                if (sync_acc != SYNC_PATTERN) begin
                    res.status = STATUS_BAD_SYNC;
                end else if (overlong || byte_cnt < MIN_PACKET_BYTES || len_acc != byte_cnt) begin
                    res.status = STATUS_BAD_LENGTH;
                end else if (type_acc != wanted_type) begin
                    res.status = STATUS_BAD_TYPE;
                end else if (crc_acc != tail_word) begin
                    res.status = STATUS_BAD_CRC;
                end else if (!skip_counter && next_count != count_acc) begin
                    res.status = STATUS_BAD_COUNTER;
                end else begin
                    res.status = STATUS_OK;
                end
                res.sequence_number = count_acc;
                if (res.status == STATUS_OK || res.status == STATUS_BAD_COUNTER) begin
                    prev_count = count_acc;
                end
                expected_status_q = {expected_status_q, res};
                clear_frame();
            end
        endfunction

        // Compares one result transaction with the oldest expected status.
        function void check_status(scpv_out_t got);
            scpv_out_t want;
            if (expected_status_q.size() == 0) begin
                flag($sformatf("result with nothing expected: status %0d seq 0x%02h",
                               got.status, got.sequence_number));
            end else begin
                want = expected_status_q.pop_front();
                if (got.status != want.status) begin
                    flag($sformatf("status expected %0d, got %0d", want.status, got.status));
                end
                if (got.sequence_number != want.sequence_number) begin
                    flag($sformatf("sequence expected 0x%02h, got 0x%02h",
                                   want.sequence_number, got.sequence_number));
                end
            end
        endfunction

        function void final_check();
            if (expected_status_q.size() != 0) begin
                flag($sformatf("%0d expected results never arrived", expected_status_q.size()));
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    scpv_in_t   s_data;
    logic       m_valid;
    logic       m_ready;
    scpv_out_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    frame_status_scoreboard sb;
    bit no_idle      = 1'b0;
    bit hold_req     = 1'b0;
    int bytes_sent   = 0;
    int stall_cycles = 0;

    sync_crc_packet_validator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Offers one byte, idling at random first, and waits for the transaction.
    task automatic send_byte(input logic [7:0] b, input logic l);
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, last_byte: l};
        do @(posedge aclk); while (!s_ready);
        sb.note_byte('{data_byte: b, last_byte: l});
        bytes_sent++;
    endtask

    task automatic send_packet(ref logic [7:0] pkt[$]);
        for (int i = 0; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
    endtask

    // Builds an n-byte frame (n >= 12) with a CRC trailer, optionally damaged.
    function automatic void build_frame(ref logic [7:0] pkt[$], input int n,
                                        input logic [15:0] len_val, input logic [7:0] ptype,
                                        input logic [7:0] count, input bit bad_sync,
                                        input bit bad_crc);
        logic [31:0] crc;
        pkt.delete();
        for (int i = 0; i < 4; i++) begin
            pkt = {pkt, SYNC_PATTERN[8*i +: 8]};
        end
        if (bad_sync) begin
            pkt[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
        end
        pkt = {pkt, len_val[7:0]};
        pkt = {pkt, len_val[15:8]};
        pkt = {pkt, ptype};
        pkt = {pkt, count};
        while (pkt.size() < n - 4) begin
            pkt = {pkt, 8'($urandom_range(0, 255))};
        end
        crc = CRC_INIT;
        for (int i = 0; i < n - 4; i++) begin
            crc = frame_status_scoreboard::crc_update(crc, pkt[i]);
        end
        if (bad_crc) begin
            crc ^= 32'h1 << $urandom_range(0, 31);
        end
        for (int i = 0; i < 4; i++) begin
            pkt = {pkt, crc[8*i +: 8]};
        end
    endfunction

    // Mostly well-formed frames with random content, some damaged fields,
    // some truncated frames and some plain noise.
    task automatic send_random_packet();
        logic [7:0]  pkt[$];
        int          sel;
        int          n;
        logic [15:0] len_val;
        logic [7:0]  ptype;
        logic [7:0]  count;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
                pkt = {pkt, 8'($urandom_range(0, 255))};
            end
        end else begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 300) : $urandom_range(12, 40);
            len_val = 16'(n);
            if ($urandom_range(0, 99) < 6) begin
                len_val = $urandom_range(0, 1) ? 16'(n + 1) : 16'($urandom_range(0, 65535));
            end
            ptype = ($urandom_range(0, 99) < 10) ? 8'($urandom_range(0, 255)) : sb.wanted_type;
            count = ($urandom_range(0, 99) < 10) ? 8'($urandom_range(0, 255))
                                                 : sb.prev_count + 8'd1;
            build_frame(pkt, n, len_val, ptype, count,
                        $urandom_range(0, 99) < 6, $urandom_range(0, 99) < 8);
            if (sel < 18) begin
                n = $urandom_range(1, 11);
                while (pkt.size() > n) void'(pkt.pop_back());
            end
        end
        send_packet(pkt);
    endtask

    // Drops valid and waits until every expected result has come out.
    task automatic pause_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_status_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [7:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Writes both registers plus one index past the register map.
    task automatic configure(input logic [7:0] type_val, input logic [7:0] skip_val,
                             input logic [7:0] junk_idx);
        put_reg(CFG_WANTED_TYPE, type_val);
        put_reg(CFG_SKIP_COUNTER, skip_val);
        put_reg(junk_idx, 8'($urandom_range(0, 255)));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random back-pressure, plus a long hold-off when requested.
    initial begin
        int hold_left;
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    // Every result transaction is checked against the predicted status.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_status(m_data);
        end
    end

    // Ends the run if no transaction of any channel happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL sync_crc_packet_validator");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [7:0] pkt[$];
        int         start;
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = 8'h00;
        cfg_data  = 8'h00;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: a lone last byte, a short frame without its sequence byte,
        // a counter error at 0xFF, then a good frame that wraps the counter.
        pkt.delete();
        pkt = {pkt, 8'hFF};
        send_packet(pkt);
        build_frame(pkt, 12, 16'd12, 8'h00, 8'hFF, 1'b0, 1'b0);
        while (pkt.size() > 7) void'(pkt.pop_back());
        send_packet(pkt);
        build_frame(pkt, 12, 16'd12, 8'h00, 8'hFF, 1'b0, 1'b0);
        send_packet(pkt);
        build_frame(pkt, 12, 16'd12, 8'h00, 8'h00, 1'b0, 1'b0);
        send_packet(pkt);

        // A frame with the all-ones type and the counter check turned off.
        pause_sender();
        configure(8'hFF, 8'hFF, 8'hFF);
        build_frame(pkt, 40, 16'd40, 8'hFF, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_packet(pkt);
        pause_sender();
        configure(8'h00, 8'hFE, 8'h02);

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase > 0) begin
                pause_sender();
                configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(2, 255)));
            end
            no_idle = (phase == 2);
            if (phase == 3) begin
                // Hold the receiver off while short frames keep coming.
                hold_req = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    build_frame(pkt, 12, 16'd12, sb.wanted_type, sb.prev_count + 8'd1,
                                1'b0, 1'b0);
                    send_packet(pkt);
                end
            end
            start = bytes_sent;
            while (bytes_sent - start < RANDOM_ITEMS / RANDOM_PHASES) begin
                send_random_packet();
            end
        end
        no_idle = 1'b0;

        pause_sender();
        repeat (8) @(posedge aclk);
        sb.final_check();
        if (sb.mismatches == 0) begin
            $display("PASS sync_crc_packet_validator");
        end else begin
            $display("FAIL sync_crc_packet_validator");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/scpv_pkg.sv
hdl/sync_crc_packet_validator.sv
hdl/scpv_checker.sv
dv/tb.sv
